// ----- design/sapq_pkg.sv -----
package sapq_pkg;

   // field widths fixed by the interface
   localparam int unsigned ValueWidth   = 32;
   localparam int unsigned CmdWidth     = 2;
   localparam int unsigned StatusWidth  = 2;
   localparam int unsigned CountOutWidth = 5;

   // command codes
   localparam logic [CmdWidth-1:0] CMD_INSERT = 2'd0;
   localparam logic [CmdWidth-1:0] CMD_DELETE = 2'd1;
   localparam logic [CmdWidth-1:0] CMD_QUERY  = 2'd2;

   // status codes
   localparam logic [StatusWidth-1:0] ST_OK    = 2'd0;
   localparam logic [StatusWidth-1:0] ST_FULL  = 2'd1;
   localparam logic [StatusWidth-1:0] ST_EMPTY = 2'd2;

   // control broadcast to every cell of the row
   typedef struct packed {
      logic                          shift_in;
      logic                          shift_out;
      logic signed [ValueWidth-1:0]  key;
   } sapq_ctl_type;

endpackage

// ----- design/sapq_cell.sv -----
module sapq_cell (
   input  logic                                  clock,
   input  sapq_pkg::sapq_ctl_type                ctl,
   input  logic                                  live,
   input  logic signed [sapq_pkg::ValueWidth-1:0] left_val,
   input  logic                                  left_gt,
   input  logic signed [sapq_pkg::ValueWidth-1:0] right_val,
   output logic signed [sapq_pkg::ValueWidth-1:0] val,
   output logic                                  gt
);
   import sapq_pkg::*;

   logic signed [ValueWidth-1:0] val_ff;
   logic signed [ValueWidth-1:0] val_in;

   // this live entry is strictly larger than the key being inserted
   assign gt  = live && (val_ff > ctl.key);
   assign val = val_ff;

   // insert: larger entries move up, the first slot past the smaller ones takes the key
   // delete: every entry moves down one slot
   always_comb begin
      val_in = val_ff;
      if (ctl.shift_in) begin
         if (left_gt) begin
            val_in = left_val;
         end else if (gt || !live) begin
            val_in = ctl.key;
         end
      end else if (ctl.shift_out) begin
         val_in = right_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

// ----- design/sorted_array_priority_queue.sv -----
// Sorted-array priority queue of signed 32-bit values, DEPTH entries deep.
// Input channel req_*: command (insert, delete smallest, query smallest and
// largest) with a value that only insert uses. Result channel rsp_*: one
// transaction per command carrying status, min_value, max_value and the
// entry count after the command.
// Entries sit in a row of cells, smallest in cell 0. Each cell compares its
// entry with the incoming key in parallel, so an insert or delete moves the
// whole row by one slot together.
// The result is registered and appears in the cycle after the command is accepted.
// Throughput: one command per cycle while req_stall is low; the compare in
// every cell plus the neighbor select sets the cycle.
// A result waiting in the output register does not block a new command as
// long as rsp_stall is low; while rsp_stall is high and a result is held,
// req_stall is high and the held result stays unchanged.
// Reset empties the queue (count zero) and drops any pending result; the
// entry storage itself is not cleared, only the count marks what is live.
module sorted_array_priority_queue #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [sapq_pkg::CmdWidth-1:0]          req_command,
   input  logic signed [sapq_pkg::ValueWidth-1:0] req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [sapq_pkg::StatusWidth-1:0]       rsp_status,
   output logic signed [sapq_pkg::ValueWidth-1:0] rsp_min_value,
   output logic signed [sapq_pkg::ValueWidth-1:0] rsp_max_value,
   output logic [sapq_pkg::CountOutWidth-1:0]     rsp_count
);
   import sapq_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [CW-1:0]                count_ff, count_in;
   logic signed [ValueWidth-1:0] max_ff, max_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [StatusWidth-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [ValueWidth-1:0] rsp_min_ff, rsp_min_in;
   logic signed [ValueWidth-1:0] rsp_max_ff, rsp_max_in;
   logic [CountOutWidth-1:0]     rsp_count_ff, rsp_count_in;

   logic                         accept, full, empty, do_ins, do_del;
   sapq_ctl_type                 ctl;

   logic signed [ValueWidth-1:0] cell_val [DEPTH];
   logic                         cell_gt  [DEPTH];

   // handshake: take a command unless a held result is stalled
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);
   assign do_ins = accept && (req_command == CMD_INSERT) && !full;
   assign do_del = accept && (req_command == CMD_DELETE) && !empty;

   assign ctl.shift_in  = do_ins;
   assign ctl.shift_out = do_del;
   assign ctl.key       = req_value;

   // row of cells, each talking to its neighbors; the end cells have only one
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [ValueWidth-1:0] left_val, right_val;
      logic                         left_gt;

      if (i == 0) begin : g_first
         assign left_val = '0;
         assign left_gt  = 1'b0;
      end else begin : g_mid
         assign left_val = cell_val[i-1];
         assign left_gt  = cell_gt[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_val = '0;
      end else begin : g_inner
         assign right_val = cell_val[i+1];
      end

      sapq_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .live      (CW'(i) < count_ff),
         .left_val  (left_val),
         .left_gt   (left_gt),
         .right_val (right_val),
         .val       (cell_val[i]),
         .gt        (cell_gt[i])
      );
   end

   // count and largest entry track the row
   always_comb begin
      count_in = count_ff;
      max_in   = max_ff;
      if (do_ins) begin
         count_in = count_ff + CW'(1);
         if (empty || (req_value >= max_ff)) begin
            max_in = req_value;
         end
      end else if (do_del) begin
         count_in = count_ff - CW'(1);
      end
   end

   // result of the accepted command
   always_comb begin
      rsp_status_in = ST_OK;
      rsp_min_in    = '0;
      rsp_max_in    = '0;
      rsp_count_in  = CountOutWidth'(count_in);
      unique case (req_command)
         CMD_INSERT: begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end
         end
         CMD_DELETE: begin
            if (empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_min_in = cell_val[0];
            end
         end
         CMD_QUERY: begin
            if (empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_min_in = cell_val[0];
               rsp_max_in = max_ff;
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      max_ff <= max_in;
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_min_ff    <= rsp_min_in;
         rsp_max_ff    <= rsp_max_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_min_value = rsp_min_ff;
   assign rsp_max_value = rsp_max_ff;
   assign rsp_count     = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above capacity");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      accept && (req_command == CMD_INSERT) && full |=> rsp_status == ST_FULL)
      else $error("insert into full queue not reported");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      do_ins |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the count");

   a_del_count: assert property (@(posedge clock) disable iff (reset)
      do_del |=> count_ff == $past(count_ff) - CW'(1))
      else $error("delete did not shrink the count");

   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> cell_val[0] <= max_ff)
      else $error("smallest entry above tracked largest");
`endif

endmodule
